/* rtl/core/fnvd_pkg.sv */
// Shared types, constants and arithmetic helpers for the vertex displacement unit.
package fnvd_pkg;

  localparam int FracBits = 24;
  localparam int PointW   = 40;
  localparam int DirW     = 24;
  localparam int OctLat   = 7;

  localparam logic [23:0] HashScale = 24'd5340354;
  localparam logic [23:0] HashOffX  = 24'd11911823;
  localparam logic [23:0] HashOffY  = 24'd1895825;
  localparam logic [23:0] HashOffZ  = 24'd7029654;
  localparam logic [28:0] HashAdd   = 29'd321954775;

  localparam logic [19:0] SeedRecip = 20'd671089;
  localparam logic [4:0]  SeedDiv   = 5'd25;

  typedef logic signed [PointW-1:0] pt_t;
  typedef logic signed [DirW-1:0]   dir_t;
  typedef logic [23:0]              frac_t;

  typedef enum logic [7:0] {
    RegFrequency = 8'd0,
    RegAmplitude = 8'd1,
    RegRadius    = 8'd2,
    RegSeed      = 8'd3
  } cfg_reg_e;

  // Fraction part of b * 2^22 / 25, rounded as the seed offset needs.
  function automatic logic [21:0] seed_frac(input logic [4:0] b);
    logic [21:0] r;
    unique case (b)
      5'd0:  r = 22'd0;
      5'd1:  r = 22'd167772;
      5'd2:  r = 22'd335544;
      5'd3:  r = 22'd503316;
      5'd4:  r = 22'd671089;
      5'd5:  r = 22'd838861;
      5'd6:  r = 22'd1006633;
      5'd7:  r = 22'd1174405;
      5'd8:  r = 22'd1342177;
      5'd9:  r = 22'd1509949;
      5'd10: r = 22'd1677722;
      5'd11: r = 22'd1845494;
      5'd12: r = 22'd2013266;
      5'd13: r = 22'd2181038;
      5'd14: r = 22'd2348810;
      5'd15: r = 22'd2516582;
      5'd16: r = 22'd2684355;
      5'd17: r = 22'd2852127;
      5'd18: r = 22'd3019899;
      5'd19: r = 22'd3187671;
      5'd20: r = 22'd3355443;
      5'd21: r = 22'd3523215;
      5'd22: r = 22'd3690988;
      5'd23: r = 22'd3858760;
      5'd24: r = 22'd4026532;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

  function automatic frac_t lerp(input frac_t a, input frac_t b, input frac_t t);
    logic [24:0] tc;
    logic [49:0] acc;
    tc  = 25'h1000000 - {1'b0, t};
    acc = 50'(a) * 50'(tc) + 50'(b) * 50'(t);
    return acc[47:24];
  endfunction

endpackage

/* rtl/core/fnvd_in_if.sv */
// Vertex direction input channel.
interface fnvd_in_if;
  logic               valid;
  logic               ready;
  fnvd_pkg::dir_t     dir_x;
  fnvd_pkg::dir_t     dir_y;
  fnvd_pkg::dir_t     dir_z;
  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

/* rtl/core/fnvd_out_if.sv */
// Displaced position result channel.
interface fnvd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [16:0]        noise_sum;
  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output noise_sum, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                  input noise_sum, output ready);
endinterface

/* rtl/core/fnvd_cfg_if.sv */
// Register write channel.
interface fnvd_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [23:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/fnvd_octave.sv */
// One octave of 3D value noise, seven register stages.
module fnvd_octave #(
  parameter int OCT = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  fnvd_pkg::pt_t   p_i [3],
  output fnvd_pkg::frac_t noise_o
);
  import fnvd_pkg::*;

  localparam logic [23:0] Off [3] = '{HashOffX, HashOffY, HashOffZ};

  frac_t       qa_q [3][2];
  frac_t       fa_q [3];
  frac_t       f2_q [3];
  frac_t       qb_q [3][2];
  frac_t       ub_q [3];
  logic [28:0] pr_q [3][2][2];
  frac_t       uc_q [3];
  logic [31:0] sc_q [8];
  logic [30:0] zc_q [8];
  frac_t       ud_q [3];
  frac_t       h_q  [8];
  frac_t       ue_q [2];
  frac_t       xb_q [4];
  frac_t       uf_q;
  frac_t       yb_q [2];
  frac_t       noise_q;

  frac_t       qa_d [3][2];
  frac_t       fa_d [3];
  frac_t       f2_d [3];
  frac_t       ub_d [3];
  logic [28:0] pr_d [3][2][2];
  logic [31:0] sc_d [8];
  logic [30:0] zc_d [8];
  frac_t       h_d  [8];

  always_comb begin
    logic [47:0] wide;
    logic [39:0] po;
    logic [23:0] ix;
    logic [47:0] prod;
    for (int k = 0; k < 3; k++) begin
      wide = {{8{p_i[k][39]}}, p_i[k]} << OCT;
      if ((&wide[47:39]) || !(|wide[47:39])) begin
        po = wide[39:0];
      end else if (wide[47]) begin
        po = {1'b1, 39'd0};
      end else begin
        po = {1'b0, {39{1'b1}}};
      end
      ix         = {{8{po[39]}}, po[39:24]};
      prod       = ix * HashScale;
      qa_d[k][0] = prod[23:0] + Off[k];
      qa_d[k][1] = prod[23:0] + Off[k] + HashScale;
      fa_d[k]    = po[23:0];
      prod       = po[23:0] * po[23:0];
      f2_d[k]    = prod[47:24];
    end
  end

  always_comb begin
    logic [25:0] tw;
    logic [49:0] sp;
    logic [52:0] hp;
    for (int k = 0; k < 3; k++) begin
      tw     = 26'h3000000 - {1'b0, fa_q[k], 1'b0};
      sp     = f2_q[k] * tw;
      ub_d[k] = sp[47:24];
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          hp = qa_q[k][i] * ({5'd0, qa_q[(k + 1) % 3][j]} + HashAdd);
          pr_d[k][i][j] = hp[52:24];
        end
      end
    end
  end

  always_comb begin
    logic [30:0] dot;
    int i, j, k;
    for (int c = 0; c < 8; c++) begin
      i = c % 2;
      j = (c / 2) % 2;
      k = c / 4;
      dot = 31'(pr_q[0][i][j]) + 31'(pr_q[1][j][k]) + 31'(pr_q[2][k][i]);
      sc_d[c] = 32'(qb_q[0][i]) + 32'(qb_q[1][j]) + {dot, 1'b0};
      zc_d[c] = 31'(qb_q[2][k]) + dot;
    end
  end

  always_comb begin
    logic [62:0] hp;
    for (int c = 0; c < 8; c++) begin
      hp     = sc_q[c] * zc_q[c];
      h_d[c] = hp[47:24];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qa_q <= qa_d;
      fa_q <= fa_d;
      f2_q <= f2_d;
      qb_q <= qa_q;
      ub_q <= ub_d;
      pr_q <= pr_d;
      uc_q <= ub_q;
      sc_q <= sc_d;
      zc_q <= zc_d;
      ud_q <= uc_q;
      h_q  <= h_d;
      ue_q <= '{ud_q[1], ud_q[2]};
      for (int m = 0; m < 4; m++) begin
        xb_q[m] <= lerp(h_q[2 * m], h_q[2 * m + 1], ud_q[0]);
      end
      uf_q <= ue_q[1];
      for (int k = 0; k < 2; k++) begin
        yb_q[k] <= lerp(xb_q[2 * k], xb_q[2 * k + 1], ue_q[0]);
      end
      noise_q <= lerp(yb_q[0], yb_q[1], uf_q);
    end
  end

  assign noise_o = noise_q;

endmodule

/* rtl/core/fractal_noise_vertex_displace_unit.sv */
// Fractal value noise vertex displacement unit, top level.
// Takes one vertex direction per cycle and returns one displaced position and
// its noise sum per cycle. The whole datapath is one pipeline that advances
// together: when the result register is full and not taken, every stage holds
// and the input is not ready. The octaves are computed side by side, one noise
// unit each. Register writes take effect at once and can reach vertices
// already in the pipeline.
module fractal_noise_vertex_displace_unit #(
  parameter int OCTAVES = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  fnvd_in_if.sink    in_i,
  fnvd_out_if.source out_o,
  fnvd_cfg_if.sink   cfg_i
);
  import fnvd_pkg::*;

  localparam int Stages = 7 + OctLat;
  localparam int SumSt  = 3 + OctLat;

  logic [23:0] frequency_q;
  logic [19:0] amplitude_q;
  logic [23:0] radius_q;
  logic [39:0] offset_q;
  logic [39:0] offset_d;

  logic [Stages:1] vld_q;
  logic            en;

  dir_t               d_q [Stages-2:1][3];
  logic signed [48:0] fp_q [3];
  pt_t                p_q [3];
  frac_t              noise [OCTAVES];
  logic [25:0]        n_q;
  logic [25:0]        n_d;
  logic [16:0]        ns_q [Stages:SumSt];
  logic signed [47:0] m1_q;
  logic signed [56:0] m2_q;
  logic signed [44:0] lo_q [3];
  logic signed [43:0] hi_q [3];
  logic signed [31:0] pos_q [3];
  logic signed [31:0] pos_d [3];

  assign en        = !vld_q[Stages] || out_o.ready;
  assign in_i.ready = en;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    logic [35:0] qp;
    logic [15:0] a;
    logic [20:0] r;
    qp = cfg_i.data[15:0] * SeedRecip;
    a  = {4'd0, qp[35:24]};
    r  = 21'(cfg_i.data[15:0]) - 21'(a * SeedDiv);
    offset_d = {6'd0, a[11:0], seed_frac(r[4:0])};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frequency_q <= 24'd65536;
      amplitude_q <= 20'd19661;
      radius_q    <= 24'd65536;
      offset_q    <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegFrequency: frequency_q <= cfg_i.data;
        RegAmplitude: amplitude_q <= cfg_i.data[19:0];
        RegRadius:    radius_q    <= cfg_i.data;
        RegSeed:      offset_q    <= offset_d;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Stages-1:1], in_i.valid};
    end
  end

  always_comb begin
    n_d = '0;
    for (int o = 0; o < OCTAVES; o++) begin
      n_d = n_d + 26'(noise[o] >> o);
    end
  end

  always_comb begin
    logic signed [63:0] full;
    for (int k = 0; k < 3; k++) begin
      full = (64'(hi_q[k]) <<< 20) + 64'(lo_q[k]);
      full = full >>> 30;
      if (full > 64'sd2147483647) begin
        pos_d[k] = 32'sh7fffffff;
      end else if (full < -64'sd2147483648) begin
        pos_d[k] = 32'sh80000000;
      end else begin
        pos_d[k] = full[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [31:0] disp;
    logic signed [39:0] s;
    if (en) begin
      d_q[1] <= '{in_i.dir_x, in_i.dir_y, in_i.dir_z};
      for (int s1 = 2; s1 <= Stages - 2; s1++) begin
        d_q[s1] <= d_q[s1-1];
      end
      for (int k = 0; k < 3; k++) begin
        p_q[k]  <= 40'(fp_q[k] >>> 14) + $signed(offset_q);
      end
      fp_q[0] <= 49'(in_i.dir_x) * 49'($signed({1'b0, frequency_q}));
      fp_q[1] <= 49'(in_i.dir_y) * 49'($signed({1'b0, frequency_q}));
      fp_q[2] <= 49'(in_i.dir_z) * 49'($signed({1'b0, frequency_q}));
      n_q        <= n_d;
      ns_q[SumSt] <= n_d[24:8];
      for (int s2 = SumSt + 1; s2 <= Stages; s2++) begin
        ns_q[s2] <= ns_q[s2-1];
      end
      m1_q <= 48'($signed({1'b0, n_q}) - 27'sd8388608) * 48'($signed({1'b0, amplitude_q}));
      disp = 32'sd16777216 + 32'(m1_q >>> 16);
      m2_q <= 57'($signed({1'b0, radius_q})) * 57'(disp);
      s    = 40'(m2_q >>> 16);
      for (int k = 0; k < 3; k++) begin
        lo_q[k]  <= 45'(d_q[Stages-2][k]) * 45'($signed({1'b0, s[19:0]}));
        hi_q[k]  <= 44'(d_q[Stages-2][k]) * 44'($signed(s[39:20]));
        pos_q[k] <= pos_d[k];
      end
    end
  end

  for (genvar o = 0; o < OCTAVES; o++) begin : g_oct
    fnvd_octave #(
      .OCT(o)
    ) u_octave (
      .clk_i  (clk_i),
      .en_i   (en),
      .p_i    (p_q),
      .noise_o(noise[o])
    );
  end

  assign out_o.valid     = vld_q[Stages];
  assign out_o.pos_x     = pos_q[0];
  assign out_o.pos_y     = pos_q[1];
  assign out_o.pos_z     = pos_q[2];
  assign out_o.noise_sum = ns_q[Stages];

endmodule
